FILE: rtl/core/assert_macros.svh
// assertion helpers included by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, masked while reset is high
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// condition in one cycle requires a property in the next
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/core/rldc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rldc_pkg
// types, codes and helper functions of the route label director codec
// ----------------------------------------------------------------------------
package rldc_pkg;

  localparam int NUM_FORM_REGS = 4;
  localparam int LABEL_LIMIT   = 59;
  localparam int WORD_W        = 41;
  localparam int IN_TDATA_W    = 104;
  localparam int OUT_TDATA_W   = 104;

  // operations
  localparam logic [1:0] OP_PARSE     = 2'd0;
  localparam logic [1:0] OP_SERIALIZE = 2'd1;
  localparam logic [1:0] OP_CONVERT   = 2'd2;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FORM  = 2'd1;
  localparam logic [1:0] ST_NO_REP   = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // register indexes
  localparam logic [2:0] REG_FORM_COUNT = 3'd0;
  localparam logic [2:0] REG_FORM0      = 3'd1;
  localparam logic [2:0] REG_FORM1      = 3'd2;
  localparam logic [2:0] REG_FORM2      = 3'd3;
  localparam logic [2:0] REG_FORM3      = 3'd4;

  // reset contents: the 3/5/8 scheme
  localparam logic [2:0]        RST_FORM_COUNT = 3'd3;
  localparam logic [WORD_W-1:0] RST_FORM0      = 41'd1121;
  localparam logic [WORD_W-1:0] RST_FORM1      = 41'd2210;
  localparam logic [WORD_W-1:0] RST_FORM2      = 41'd258;
  localparam logic [WORD_W-1:0] RST_FORM3      = 41'd0;

  // same bit layout as a form word
  typedef struct packed {
    logic [30:0] prefix;
    logic [4:0]  bits;
    logic [4:0]  plen;
  } form_t;

  typedef form_t [NUM_FORM_REGS-1:0] form_set_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] idx;
  } match_t;

  function automatic logic [63:0] low_mask(logic [5:0] n);
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic logic [5:0] floor_log2(logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  // first form whose prefix matches the label's low bits; with a single form, form 0 always matches
  function automatic match_t match_form(logic [63:0] label, form_set_t forms,
                                        logic [2:0] nforms);
    match_t     m;
    logic [63:0] msk;
    m = '0;
    if (nforms == 3'd1) begin
      m.ok  = 1'b1;
      m.idx = 2'd0;
    end else begin
      for (int i = NUM_FORM_REGS - 1; i >= 0; i--) begin
        msk = low_mask({1'b0, forms[i].plen});
        if ((3'(i) < nforms) && ((({33'd0, forms[i].prefix} ^ label) & msk) == 64'd0)) begin
          m.ok  = 1'b1;
          m.idx = 2'(i);
        end
      end
    end
    return m;
  endfunction

  function automatic logic is_358(form_set_t forms, logic [2:0] nforms);
    return (nforms == 3'd3) &&
           forms[0].bits == 5'd3 && forms[0].plen == 5'd1 && forms[0].prefix == 31'd1 &&
           forms[1].bits == 5'd5 && forms[1].plen == 5'd2 && forms[1].prefix == 31'd2 &&
           forms[2].bits == 5'd8 && forms[2].plen == 5'd2 && forms[2].prefix == 31'd0;
  endfunction

endpackage

FILE: rtl/core/route_label_director_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_label_director_codec
// parses, serializes and converts variable-width route label directors
// ----------------------------------------------------------------------------
// Five register stages (match, parse, form select, serialize, output) with one
// shared advance signal: an item is taken every cycle while the output side
// takes results. The edge that accepts a transaction loads the match stage; its
// result then moves through the parse, form select, serialize and output
// registers before it is offered on m_tvalid. A stall at m_tready freezes every
// stage and lowers s_tready in the same cycle.
// Form words and the form count are written through the cfg port, which is
// always ready; write them only while no item is in flight. The 3/5/8 scheme
// is recognized by comparing the programmed forms and changes slot numbering.
module route_label_director_codec
  import rldc_pkg::*;
#(
  parameter int MAX_FORMS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  // cfg write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // route_label[63:0], director[95:64], target_form[98:96], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // operation[1:0]
  input  logic [1:0]             s_tuser,
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // form_index[1:0], director_out[33:2], label_out[97:34], self_route[98],
  // one_hop[99], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]             m_tuser
);

  localparam int FORM_LIM = (MAX_FORMS < NUM_FORM_REGS) ? MAX_FORMS : NUM_FORM_REGS;

  // configuration registers
  logic [2:0]  form_count;
  form_set_t   forms;
  logic [2:0]  nforms;
  logic        scheme_358;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      form_count <= RST_FORM_COUNT;
      forms[0]   <= form_t'(RST_FORM0);
      forms[1]   <= form_t'(RST_FORM1);
      forms[2]   <= form_t'(RST_FORM2);
      forms[3]   <= form_t'(RST_FORM3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FORM_COUNT: form_count <= cfg_data[2:0];
        REG_FORM0:      forms[0]   <= form_t'(cfg_data);
        REG_FORM1:      forms[1]   <= form_t'(cfg_data);
        REG_FORM2:      forms[2]   <= form_t'(cfg_data);
        REG_FORM3:      forms[3]   <= form_t'(cfg_data);
        default: ;  // indexes beyond the list are dropped
      endcase
    end
  end

  // forms in use, clamped to 1..FORM_LIM
  always_comb begin
    if (form_count == 3'd0) begin
      nforms = 3'd1;
    end else if (form_count > 3'(FORM_LIM)) begin
      nforms = 3'(FORM_LIM);
    end else begin
      nforms = form_count;
    end
  end

  assign scheme_358 = is_358(forms, nforms);

  // global advance: the whole pipe moves when the output slot frees up
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      m_tvalid <= v4;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: input form match and label length
  // --------------------------------------------------------------------------
  logic [1:0]  p1_op;
  logic [63:0] p1_label;
  logic [31:0] p1_dir;
  logic [2:0]  p1_target;
  match_t      p1_m;
  logic [5:0]  p1_lg;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_op     <= s_tuser;
      p1_label  <= s_tdata[63:0];
      p1_dir    <= s_tdata[95:64];
      p1_target <= s_tdata[98:96];
      p1_m      <= match_form(s_tdata[63:0], forms, nforms);
      p1_lg     <= floor_log2(s_tdata[63:0]);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: director extraction, flags, label remainder
  // --------------------------------------------------------------------------
  form_t       f1;
  logic [63:0] sh1, mask_b, mask_w;
  logic [30:0] d_raw;
  logic [31:0] d_par;
  logic [5:0]  w1;
  logic        self_c;

  always_comb begin
    f1     = forms[p1_m.idx];
    sh1    = p1_label >> f1.plen;
    mask_b = low_mask({1'b0, f1.bits});
    d_raw  = sh1[30:0] & mask_b[30:0];
    w1     = {1'b0, f1.plen} + {1'b0, f1.bits};
    mask_w = low_mask(w1);
    d_par  = {1'b0, d_raw};
    if (scheme_358) begin
      // slot 1 is skipped outside form 0, slots 0 and 1 swap inside it
      if (p1_m.idx != 2'd0) begin
        if (d_raw != 31'd0) d_par = {1'b0, d_raw} + 32'd1;
      end else if (d_raw == 31'd0) begin
        d_par = 32'd1;
      end else if (d_raw == 31'd1) begin
        d_par = 32'd0;
      end
      self_c = p1_m.ok && ((p1_label & mask_w) == 64'd1);
    end else begin
      self_c = (p1_label == 64'd1);
    end
  end

  logic [1:0]  p2_op;
  logic [2:0]  p2_target;
  match_t      p2_m;
  logic [31:0] p2_d, p2_sd;
  logic        p2_self, p2_hop;
  logic [63:0] p2_rest;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_op     <= p1_op;
      p2_target <= p1_target;
      p2_m      <= p1_m;
      p2_d      <= d_par;
      p2_sd     <= (p1_op == OP_SERIALIZE) ? p1_dir : d_par;
      p2_self   <= self_c;
      p2_hop    <= p1_m.ok && (p1_lg == w1);
      p2_rest   <= p1_label >> w1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: output form selection and slot remap
  // --------------------------------------------------------------------------
  logic        found, sub, fit, f_ok, ser_ok_c;
  logic [1:0]  f_auto, f_sel;
  logic [31:0] v_try, d_adj;

  always_comb begin
    found  = 1'b0;
    f_auto = 2'd0;
    // smallest form index that holds the director
    for (int i = NUM_FORM_REGS - 1; i >= 0; i--) begin
      sub   = scheme_358 && (i != 0);
      v_try = sub ? (p2_sd - 32'd1) : p2_sd;
      fit   = !(sub && p2_sd == 32'd0) && ((v_try >> forms[i].bits) == 32'd0);
      if ((3'(i) < nforms) && fit) begin
        found  = 1'b1;
        f_auto = 2'(i);
      end
    end
    if (p2_target[2]) begin
      f_sel = f_auto;
      f_ok  = found;
    end else begin
      f_sel = p2_target[1:0];
      f_ok  = p2_target < nforms;
    end
    d_adj    = p2_sd;
    ser_ok_c = f_ok;
    if (scheme_358) begin
      if (f_sel != 2'd0) begin
        if (p2_sd == 32'd1) ser_ok_c = 1'b0;
        if (p2_sd != 32'd0) d_adj = p2_sd - 32'd1;
      end else if (p2_sd == 32'd0) begin
        d_adj = 32'd1;
      end else if (p2_sd == 32'd1) begin
        d_adj = 32'd0;
      end
    end
  end

  logic [1:0]  p3_op;
  match_t      p3_m;
  logic [31:0] p3_d, p3_dadj;
  logic        p3_self, p3_hop, p3_ser_ok;
  logic [63:0] p3_rest;
  logic [5:0]  p3_lr;
  logic [1:0]  p3_fo;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_op     <= p2_op;
      p3_m      <= p2_m;
      p3_d      <= p2_d;
      p3_dadj   <= d_adj;
      p3_self   <= p2_self;
      p3_hop    <= p2_hop;
      p3_ser_ok <= ser_ok_c;
      p3_rest   <= p2_rest;
      p3_lr     <= floor_log2(p2_rest);
      p3_fo     <= f_sel;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: serialized director
  // --------------------------------------------------------------------------
  form_t fo_form;
  assign fo_form = forms[p3_fo];

  logic [1:0]  p4_op;
  match_t      p4_m;
  logic [31:0] p4_d;
  logic        p4_self, p4_hop, p4_ser_ok;
  logic [63:0] p4_rest, p4_s;
  logic [5:0]  p4_lr;
  logic [1:0]  p4_fo;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_op     <= p3_op;
      p4_m      <= p3_m;
      p4_d      <= p3_d;
      p4_self   <= p3_self;
      p4_hop    <= p3_hop;
      p4_ser_ok <= p3_ser_ok;
      p4_rest   <= p3_rest;
      p4_lr     <= p3_lr;
      p4_fo     <= p3_fo;
      p4_s      <= ({32'd0, p3_dadj} << fo_form.plen) | {33'd0, fo_form.prefix};
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: converted label, length check, result assembly
  // --------------------------------------------------------------------------
  match_t      m5;
  logic [1:0]  of;
  form_t       of_form;
  logic [5:0]  ob;
  logic        too_long;
  logic [63:0] conv;

  logic [1:0]  st_c, fidx_c;
  logic [31:0] dout_c;
  logic [63:0] lout_c;
  logic        self_o, hop_o;

  always_comb begin
    m5       = match_form(p4_s, forms, nforms);
    of       = m5.ok ? m5.idx : p4_fo;  // unmatched result keeps the chosen form
    of_form  = forms[of];
    ob       = {1'b0, of_form.plen} + {1'b0, of_form.bits};
    too_long = ({1'b0, p4_lr} + {1'b0, ob}) > 7'(LABEL_LIMIT);
    conv     = (p4_rest << ob) | p4_s;

    st_c   = ST_OK;
    fidx_c = 2'd0;
    dout_c = 32'd0;
    lout_c = 64'd0;
    self_o = 1'b0;
    hop_o  = 1'b0;
    case (p4_op)
      OP_PARSE: begin
        self_o = p4_self;  // self flag survives a failed match
        if (!p4_m.ok) begin
          st_c = ST_NO_FORM;
        end else begin
          fidx_c = p4_m.idx;
          dout_c = p4_d;
          hop_o  = p4_hop;
        end
      end
      OP_SERIALIZE: begin
        if (!p4_ser_ok) begin
          st_c = ST_NO_REP;
        end else begin
          fidx_c = p4_fo;
          lout_c = p4_s;
        end
      end
      OP_CONVERT: begin
        if (!p4_m.ok) begin
          st_c = ST_NO_FORM;
        end else if (!p4_ser_ok) begin
          st_c = ST_NO_REP;
        end else if (too_long) begin
          st_c = ST_TOO_LONG;
        end else begin
          fidx_c = of;
          dout_c = p4_d;
          lout_c = conv;
        end
      end
      default: ;  // reserved operation: all zero result
    endcase
  end

  logic [1:0]  out_status, out_fidx;
  logic [31:0] out_dout;
  logic [63:0] out_lout;
  logic        out_self, out_hop;

  always_ff @(posedge clk) begin
    if (en) begin
      out_status <= st_c;
      out_fidx   <= fidx_c;
      out_dout   <= dout_c;
      out_lout   <= lout_c;
      out_self   <= self_o;
      out_hop    <= hop_o;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {4'd0, out_hop, out_self, out_lout, out_dout, out_fidx};

  // bits of s_tdata above target_form are padding
  logic unused_pad;
  assign unused_pad = ^s_tdata[IN_TDATA_W-1:99];

endmodule

FILE: rtl/core/rldc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rldc_checker
// port-level checks on the result stream of the director codec
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rldc_checker
  import rldc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [1:0]             m_tuser
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // a stalled result keeps its status
  `ASSERT_NEXT(a_hold_status, clk, rst, m_tvalid && !m_tready, $stable(m_tuser), "status changed while stalled")

  // unmatched label reports nothing but the self flag
  `ASSERT_IMPL(a_no_form_clear, clk, rst, m_tvalid && m_tuser == ST_NO_FORM, m_tdata[97:0] == 98'd0 && !m_tdata[99], "fields set on unmatched label")

  // other errors carry an all zero payload
  `ASSERT_IMPL(a_error_clear, clk, rst, m_tvalid && (m_tuser == ST_NO_REP || m_tuser == ST_TOO_LONG), m_tdata == '0, "fields set on error result")

endmodule

bind route_label_director_codec rldc_checker u_rldc_checker (.*);
